// File: sv/dfm_pkg.sv
// Shared types, sizes and codes for the diagnostic fault-code memory.
package dfm_pkg;

    localparam int DEPTH   = 10;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CODE_W  = 24;
    localparam int STAT_W  = 8;
    localparam int TEMP_W  = 8;
    localparam int ENTRY_W = 7;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_TEMP  = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CODE_W-1:0] dtc_code;
        logic [STAT_W-1:0] new_status;
        logic [TEMP_W-1:0] temperature;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status_out;
        logic               found;
        logic [ENTRY_W-1:0] entry_count;
        logic               dropped;
        logic               changed;
    } out_item_t;

    typedef struct packed {
        logic              active;
        logic [CODE_W-1:0] key;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [STAT_W-1:0] status;
    } link_t;

    typedef struct packed {
        logic              en;
        logic              append;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;
        logic [STAT_W-1:0] status;
    } wr_t;

endpackage

// File: sv/dfm_cell.sv
// One store entry with its stage of the search chain.
module dfm_cell
    import dfm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] index,
    input  logic [CNT_W-1:0] fill,
    input  link_t            link_in,
    output link_t            link_out,
    input  wr_t              wr
);

    logic [CODE_W-1:0] code_reg;
    logic [STAT_W-1:0] status_reg;
    logic              active_reg;
    link_t             link_reg;
    link_t             link_next;
    logic              match;

    assign match = link_in.active && !link_in.hit && (CNT_W'(index) < fill)
                   && (code_reg == link_in.key);

    always_comb
    begin
        link_next = link_in;
        if (match)
        begin
            link_next.hit    = 1'b1;
            link_next.idx    = index;
            link_next.status = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= link_in.active;
        end
    end

    always_ff @(posedge clk)
    begin
        link_reg <= link_next;
        if (wr.en && (wr.idx == index))
        begin
            status_reg <= wr.status;
            if (wr.append)
            begin
                code_reg <= wr.code;
            end
        end
    end

    always_comb
    begin
        link_out        = link_reg;
        link_out.active = active_reg;
    end

endmodule

// File: sv/dtc_fault_memory.sv
// Top level of the diagnostic fault-code memory: control, registers and cell chain.
//
// Items are handled one at a time: the lookup token walks the cell chain one entry per cycle,
// then the search state captures the search result and the commit state commits the write
// and loads the result register. A clear item skips the chain and goes straight to commit.
// A result waiting in the output register does not block acceptance of the next item; only
// the commit step waits for it to be taken.
module dtc_fault_memory
    import dfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    localparam logic [1:0] REG_OVERHEAT = 2'd0;
    localparam logic [1:0] REG_RECOVER  = 2'd1;
    localparam logic [1:0] REG_MONITOR  = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_ACTIVE   = 8'h01;
    localparam logic [STAT_W-1:0] STATUS_INACTIVE = 8'h00;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [TEMP_W-1:0] overheat_reg, recover_reg;
    logic [CODE_W-1:0] monitor_reg;
    in_item_t          item_reg;
    link_t             entry_reg;
    logic              entry_active_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [STAT_W-1:0] hstat_reg;
    logic              out_valid_reg;
    out_item_t         out_reg, out_next;
    link_t             chain [DEPTH+1];
    link_t             entry_link;
    wr_t               wr;
    logic              accept, cfg_wr, out_free, commit;
    logic              do_set;
    logic [STAT_W-1:0] set_status, cur_status;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == ST_COMMIT) && out_free;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_OVERHEAT: prdata = {24'd0, overheat_reg};
            REG_RECOVER:  prdata = {24'd0, recover_reg};
            REG_MONITOR:  prdata = {8'd0, monitor_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        entry_link        = entry_reg;
        entry_link.active = entry_active_reg;
    end

    assign chain[0] = entry_link;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dfm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .index    (IDX_W'(i)),
            .fill     (fill_reg),
            .link_in  (chain[i]),
            .link_out (chain[i+1]),
            .wr       (wr)
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_item.kind == KIND_CLEAR) ? ST_COMMIT : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (chain[DEPTH].active)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        do_set     = 1'b0;
        set_status = STATUS_INACTIVE;
        cur_status = hit_reg ? hstat_reg : STATUS_INACTIVE;
        fill_next  = fill_reg;
        wr         = '0;
        wr.code    = entry_reg.key;
        out_next.status_out  = cur_status;
        out_next.found       = hit_reg;
        out_next.dropped     = 1'b0;
        out_next.changed     = 1'b0;
        case (item_reg.kind)
            KIND_SET:
            begin
                do_set     = 1'b1;
                set_status = item_reg.new_status;
            end
            KIND_QUERY:
            begin
            end
            KIND_CLEAR:
            begin
                fill_next            = '0;
                out_next.status_out  = '0;
                out_next.found       = 1'b0;
                out_next.changed     = 1'b1;
            end
            KIND_TEMP:
            begin
                if (item_reg.temperature >= overheat_reg)
                begin
                    if (cur_status == STATUS_INACTIVE)
                    begin
                        do_set     = 1'b1;
                        set_status = STATUS_ACTIVE;
                    end
                end
                else if (item_reg.temperature <= recover_reg)
                begin
                    if (cur_status == STATUS_ACTIVE)
                    begin
                        do_set     = 1'b1;
                        set_status = STATUS_INACTIVE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (do_set)
        begin
            wr.status = set_status;
            if (hit_reg)
            begin
                wr.en               = commit;
                wr.idx              = idx_reg;
                out_next.changed    = (hstat_reg != set_status);
                out_next.found      = 1'b1;
                out_next.status_out = set_status;
            end
            else if (fill_reg < CNT_W'(DEPTH))
            begin
                wr.en               = commit;
                wr.append           = 1'b1;
                wr.idx              = IDX_W'(fill_reg);
                fill_next           = fill_reg + CNT_W'(1);
                out_next.changed    = 1'b1;
                out_next.found      = 1'b1;
                out_next.status_out = set_status;
            end
            else
            begin
                out_next.dropped    = 1'b1;
                out_next.found      = 1'b0;
                out_next.status_out = '0;
            end
        end
        out_next.entry_count = ENTRY_W'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_reg         <= '0;
            entry_active_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            overheat_reg     <= 8'd120;
            recover_reg      <= 8'd100;
            monitor_reg      <= 24'h000115;
        end
        else
        begin
            state_reg        <= state_next;
            entry_active_reg <= accept && (in_item.kind != KIND_CLEAR);
            if (commit)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_OVERHEAT: overheat_reg <= pwdata[TEMP_W-1:0];
                    REG_RECOVER:  recover_reg  <= pwdata[TEMP_W-1:0];
                    REG_MONITOR:  monitor_reg  <= pwdata[CODE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg         <= in_item;
            entry_reg.active <= 1'b1;
            entry_reg.key    <= (in_item.kind == KIND_TEMP) ? monitor_reg : in_item.dtc_code;
            entry_reg.hit    <= 1'b0;
            entry_reg.idx    <= '0;
            entry_reg.status <= '0;
            hit_reg          <= 1'b0;
        end
        else if ((state_reg == ST_SEARCH) && chain[DEPTH].active)
        begin
            hit_reg   <= chain[DEPTH].hit;
            idx_reg   <= chain[DEPTH].idx;
            hstat_reg <= chain[DEPTH].status;
        end
        if (commit)
        begin
            out_reg <= out_next;
        end
    end

endmodule
